FILE: sv/scbp_pkg.sv
package scbp_pkg;

   // fixed field widths of the channels
   localparam int OP_W      = 2;
   localparam int LEN_W     = 21;
   localparam int SLOT_W    = 4;
   localparam int SEQ_OUT_W = 16;
   localparam int LIMIT_W   = 22;

   // configuration port
   localparam int CSR_DW = 32;
   localparam int CSR_AW = 4;

   // opcodes
   localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
   localparam logic [OP_W-1:0] OP_READ    = 2'd1;
   localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;

   // result status
   localparam logic ST_OK   = 1'b0;
   localparam logic ST_FAIL = 1'b1;

   // register indexes
   localparam logic [1:0] REG_SMALL_LIMIT  = 2'd0;
   localparam logic [1:0] REG_MEDIUM_LIMIT = 2'd1;
   localparam logic [1:0] REG_LARGE_LIMIT  = 2'd2;

   // limit reset values
   localparam logic [LIMIT_W-1:0] SMALL_LIMIT_RST  = 22'd131072;
   localparam logic [LIMIT_W-1:0] MEDIUM_LIMIT_RST = 22'd524288;
   localparam logic [LIMIT_W-1:0] LARGE_LIMIT_RST  = 22'd1048576;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } scbp_state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic load;
      logic exec;
   } scbp_cmd_type;

endpackage

FILE: sv/scbp_req_if.sv
interface scbp_req_if import scbp_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     opcode;
   logic [LEN_W-1:0]    length;
   logic [SLOT_W-1:0]   slot_in;

   modport source (output valid, output opcode, output length, output slot_in, input ready);
   modport sink   (input valid, input opcode, input length, input slot_in, output ready);
endinterface

FILE: sv/scbp_rsp_if.sv
interface scbp_rsp_if import scbp_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 status;
   logic [SLOT_W-1:0]    slot_out;
   logic [LEN_W-1:0]     size_out;
   logic [SEQ_OUT_W-1:0] seq_out;

   modport source (output valid, output status, output slot_out, output size_out,
                   output seq_out, input ready);
   modport sink   (input valid, input status, input slot_out, input size_out,
                   input seq_out, output ready);
endinterface

FILE: sv/size_class_buffer_pool_in_order.sv
// channel   direction  contents
// req_ch    in         opcode, length, slot_in
// rsp_ch    out        status, slot_out, size_out, seq_out
// csr       in/out     small_limit, medium_limit, large_limit at 0x0, 0x4, 0x8
//
// each word is captured first, then handled by the execute step that
// searches all slot flops and updates them; the output register decouples rsp
// a stalled rsp delays execution of the next word until the result is taken
// reset is synchronous: all slots free, counters zero, limits to defaults
module size_class_buffer_pool_in_order import scbp_pkg::*; #(
   parameter int SMALL_SLOTS  = 5,
   parameter int MEDIUM_SLOTS = 5,
   parameter int LARGE_SLOTS  = 2,
   parameter int SEQ_WIDTH    = 16
) (
   input  logic               clock,
   input  logic               reset,
   scbp_req_if.sink           req_ch,
   scbp_rsp_if.source         rsp_ch,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [CSR_AW-1:0]  paddr,
   input  logic [CSR_DW-1:0]  pwdata,
   output logic [CSR_DW-1:0]  prdata,
   output logic               pready
);

   scbp_cmd_type       cmd;
   logic [LIMIT_W-1:0] small_limit;
   logic [LIMIT_W-1:0] medium_limit;
   logic [LIMIT_W-1:0] large_limit;

   // configuration registers
   scbp_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .small_limit  (small_limit),
      .medium_limit (medium_limit),
      .large_limit  (large_limit)
   );

   // sequencing
   scbp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   // slot metadata and search
   scbp_datapath #(
      .SMALL_SLOTS  (SMALL_SLOTS),
      .MEDIUM_SLOTS (MEDIUM_SLOTS),
      .LARGE_SLOTS  (LARGE_SLOTS),
      .SEQ_WIDTH    (SEQ_WIDTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .opcode       (req_ch.opcode),
      .length       (req_ch.length),
      .slot_in      (req_ch.slot_in),
      .small_limit  (small_limit),
      .medium_limit (medium_limit),
      .large_limit  (large_limit),
      .status       (rsp_ch.status),
      .slot_out     (rsp_ch.slot_out),
      .size_out     (rsp_ch.size_out),
      .seq_out      (rsp_ch.seq_out)
   );

endmodule

FILE: sv/scbp_csr.sv
module scbp_csr import scbp_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [CSR_AW-1:0]   paddr,
   input  logic [CSR_DW-1:0]   pwdata,
   output logic [CSR_DW-1:0]   prdata,
   output logic                pready,
   output logic [LIMIT_W-1:0]  small_limit,
   output logic [LIMIT_W-1:0]  medium_limit,
   output logic [LIMIT_W-1:0]  large_limit
);

   logic [LIMIT_W-1:0] small_ff,  small_in;
   logic [LIMIT_W-1:0] medium_ff, medium_in;
   logic [LIMIT_W-1:0] large_ff,  large_in;
   logic               wr_en;
   logic [1:0]         reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[3:2];

   // register write decode
   always_comb begin
      small_in  = small_ff;
      medium_in = medium_ff;
      large_in  = large_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_SMALL_LIMIT:  small_in  = pwdata[LIMIT_W-1:0];
            REG_MEDIUM_LIMIT: medium_in = pwdata[LIMIT_W-1:0];
            REG_LARGE_LIMIT:  large_in  = pwdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         small_ff  <= SMALL_LIMIT_RST;
         medium_ff <= MEDIUM_LIMIT_RST;
         large_ff  <= LARGE_LIMIT_RST;
      end else begin
         small_ff  <= small_in;
         medium_ff <= medium_in;
         large_ff  <= large_in;
      end
   end

   // read mux
   always_comb begin
      case (reg_idx)
         REG_SMALL_LIMIT:  prdata = CSR_DW'(small_ff);
         REG_MEDIUM_LIMIT: prdata = CSR_DW'(medium_ff);
         REG_LARGE_LIMIT:  prdata = CSR_DW'(large_ff);
         default:          prdata = '0;
      endcase
   end

   assign small_limit  = small_ff;
   assign medium_limit = medium_ff;
   assign large_limit  = large_ff;

endmodule

FILE: sv/scbp_ctrl.sv
module scbp_ctrl import scbp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output scbp_cmd_type cmd
);

   scbp_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd.load  = 1'b0;
      cmd.exec  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // wait until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.exec = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // output word valid
   always_comb begin
      if (cmd.exec) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: sv/scbp_datapath.sv
module scbp_datapath import scbp_pkg::*; #(
   parameter int SMALL_SLOTS  = 5,
   parameter int MEDIUM_SLOTS = 5,
   parameter int LARGE_SLOTS  = 2,
   parameter int SEQ_WIDTH    = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  scbp_cmd_type          cmd,
   input  logic [OP_W-1:0]       opcode,
   input  logic [LEN_W-1:0]      length,
   input  logic [SLOT_W-1:0]     slot_in,
   input  logic [LIMIT_W-1:0]    small_limit,
   input  logic [LIMIT_W-1:0]    medium_limit,
   input  logic [LIMIT_W-1:0]    large_limit,
   output logic                  status,
   output logic [SLOT_W-1:0]     slot_out,
   output logic [LEN_W-1:0]      size_out,
   output logic [SEQ_OUT_W-1:0]  seq_out
);

   localparam int NUM_SLOTS = SMALL_SLOTS + MEDIUM_SLOTS + LARGE_SLOTS;
   localparam int IW        = $clog2(NUM_SLOTS);
   localparam int MED_BASE  = SMALL_SLOTS;
   localparam int LRG_BASE  = SMALL_SLOTS + MEDIUM_SLOTS;

   // captured word
   logic [OP_W-1:0]      opcode_ff;
   logic [LEN_W-1:0]     length_ff;
   logic [SLOT_W-1:0]    slot_in_ff;

   // slot metadata
   logic                 used_ff [NUM_SLOTS];
   logic                 used_in [NUM_SLOTS];
   logic [LEN_W-1:0]     size_ff [NUM_SLOTS];
   logic [LEN_W-1:0]     size_in [NUM_SLOTS];
   logic [SEQ_WIDTH-1:0] seq_ff  [NUM_SLOTS];
   logic [SEQ_WIDTH-1:0] seq_in  [NUM_SLOTS];
   logic [SEQ_WIDTH-1:0] wcount_ff, wcount_in;
   logic [SEQ_WIDTH-1:0] rcount_ff, rcount_in;

   // result register
   logic                 status_ff,   status_in;
   logic [SLOT_W-1:0]    slot_out_ff, slot_out_in;
   logic [LEN_W-1:0]     size_out_ff, size_out_in;
   logic [SEQ_OUT_W-1:0] seq_out_ff,  seq_out_in;

   // search results
   logic                 free_s, free_m, free_l;
   logic [IW-1:0]        idx_s, idx_m, idx_l;
   logic                 alloc_ok;
   logic [IW-1:0]        alloc_idx;
   logic                 read_hit;
   logic [IW-1:0]        read_idx;
   logic                 rel_ok;
   logic [IW-1:0]        rel_idx;
   logic [LIMIT_W-1:0]   len_ext;
   logic [31:0]          wseq_wide;
   logic [31:0]          rseq_wide;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         opcode_ff  <= opcode;
         length_ff  <= length;
         slot_in_ff <= slot_in;
      end
   end

   // first free slot of each class
   always_comb begin
      free_s = 1'b0;
      idx_s  = '0;
      for (int i = MED_BASE - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_s = 1'b1;
            idx_s  = IW'(i);
         end
      end
      free_m = 1'b0;
      idx_m  = '0;
      for (int i = LRG_BASE - 1; i >= MED_BASE; i--) begin
         if (!used_ff[i]) begin
            free_m = 1'b1;
            idx_m  = IW'(i);
         end
      end
      free_l = 1'b0;
      idx_l  = '0;
      for (int i = NUM_SLOTS - 1; i >= LRG_BASE; i--) begin
         if (!used_ff[i]) begin
            free_l = 1'b1;
            idx_l  = IW'(i);
         end
      end
   end

   // class selection with fall-through to larger classes
   assign len_ext = LIMIT_W'(length_ff);
   always_comb begin
      alloc_ok  = 1'b1;
      alloc_idx = '0;
      if (len_ext < small_limit && free_s) begin
         alloc_idx = idx_s;
      end else if (len_ext < medium_limit && free_m) begin
         alloc_idx = idx_m;
      end else if (len_ext < large_limit && free_l) begin
         alloc_idx = idx_l;
      end else begin
         alloc_ok = 1'b0;
      end
   end

   // lowest used slot stamped with the read count
   always_comb begin
      read_hit = 1'b0;
      read_idx = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (used_ff[i] && seq_ff[i] == rcount_ff) begin
            read_hit = 1'b1;
            read_idx = IW'(i);
         end
      end
   end

   assign rel_ok    = 32'(slot_in_ff) < 32'(NUM_SLOTS);
   assign rel_idx   = IW'(slot_in_ff);
   assign wseq_wide = 32'(wcount_ff);
   assign rseq_wide = 32'(seq_ff[read_idx]);

   // state update and result word
   always_comb begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
         used_in[i] = used_ff[i];
         size_in[i] = size_ff[i];
         seq_in[i]  = seq_ff[i];
      end
      wcount_in   = wcount_ff;
      rcount_in   = rcount_ff;
      status_in   = ST_FAIL;
      slot_out_in = '0;
      size_out_in = '0;
      seq_out_in  = '0;
      case (opcode_ff)
         OP_ALLOC: begin
            if (alloc_ok) begin
               used_in[alloc_idx] = 1'b1;
               size_in[alloc_idx] = length_ff;
               seq_in[alloc_idx]  = wcount_ff;
               wcount_in          = wcount_ff + SEQ_WIDTH'(1);
               status_in          = ST_OK;
               slot_out_in        = SLOT_W'(alloc_idx);
               size_out_in        = length_ff;
               seq_out_in         = wseq_wide[SEQ_OUT_W-1:0];
            end
         end
         OP_READ: begin
            if (read_hit) begin
               rcount_in   = rcount_ff + SEQ_WIDTH'(1);
               status_in   = ST_OK;
               slot_out_in = SLOT_W'(read_idx);
               size_out_in = size_ff[read_idx];
               seq_out_in  = rseq_wide[SEQ_OUT_W-1:0];
            end
         end
         OP_RELEASE: begin
            slot_out_in = slot_in_ff;
            if (rel_ok) begin
               used_in[rel_idx] = 1'b0;
               status_in        = ST_OK;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            used_ff[i] <= 1'b0;
         end
         wcount_ff <= '0;
         rcount_ff <= '0;
      end else if (cmd.exec) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            used_ff[i] <= used_in[i];
         end
         wcount_ff <= wcount_in;
         rcount_ff <= rcount_in;
      end
   end

   // payload registers, meaningful only while used
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            size_ff[i] <= size_in[i];
            seq_ff[i]  <= seq_in[i];
         end
         status_ff   <= status_in;
         slot_out_ff <= slot_out_in;
         size_out_ff <= size_out_in;
         seq_out_ff  <= seq_out_in;
      end
   end

   assign status   = status_ff;
   assign slot_out = slot_out_ff;
   assign size_out = size_out_ff;
   assign seq_out  = seq_out_ff;

endmodule

FILE: sv/scbp_checker.sv
module scbp_checker import scbp_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic                 rsp_status,
   input logic [SLOT_W-1:0]    rsp_slot_out,
   input logic [LEN_W-1:0]     rsp_size_out,
   input logic [SEQ_OUT_W-1:0] rsp_seq_out
);

   // a stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_slot_out) && $stable(rsp_size_out) && $stable(rsp_seq_out))
      else $error("stalled result word changed");

   // one word at a time
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("word taken while another is in flight");

   // a result is pending once a taken word has reached the execute state
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> ##1 rsp_valid)
      else $error("result missing after accepted word");

   // failures carry no size or sequence
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FAIL |-> rsp_size_out == '0 && rsp_seq_out == '0)
      else $error("failed result carries data");

   // no result straight out of reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind size_class_buffer_pool_in_order scbp_checker u_scbp_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_status   (rsp_ch.status),
   .rsp_slot_out (rsp_ch.slot_out),
   .rsp_size_out (rsp_ch.size_out),
   .rsp_seq_out  (rsp_ch.seq_out)
);

FILE: sim/tb_size_class_buffer_pool_in_order.sv
`timescale 1ns / 100ps

import scbp_pkg::*;

// pool layout: small slots first, then medium, then large
localparam int POOL_SMALL = 5;
localparam int POOL_MEDIUM = 5;
localparam int POOL_LARGE = 2;
localparam int POOL_SLOTS = POOL_SMALL + POOL_MEDIUM + POOL_LARGE;

typedef struct packed {
   logic                 status;
   logic [SLOT_W-1:0]    slot;
   logic [LEN_W-1:0]     size;
   logic [SEQ_OUT_W-1:0] seq;
} pool_result_type;

// tracks slot ownership and stamps, and holds the result words still to come
class slot_pool_model;
   logic [LIMIT_W-1:0] limit_of [3];
   bit                 slot_busy [POOL_SLOTS];
   bit [LEN_W-1:0]     slot_len [POOL_SLOTS];
   bit [15:0]          slot_stamp [POOL_SLOTS];
   bit [15:0]          next_stamp;
   bit [15:0]          next_read;
   pool_result_type    due_results [$];
   int                 faults;

   function new();
      limit_of[REG_SMALL_LIMIT] = SMALL_LIMIT_RST;
      limit_of[REG_MEDIUM_LIMIT] = MEDIUM_LIMIT_RST;
      limit_of[REG_LARGE_LIMIT] = LARGE_LIMIT_RST;
      for (int i = 0; i < POOL_SLOTS; i++) begin
         slot_busy[i] = 0;
         slot_len[i] = '0;
         slot_stamp[i] = '0;
      end
      next_stamp = '0;
      next_read = '0;
      faults = 0;
   endfunction

   function void set_limit(logic [1:0] idx, logic [LIMIT_W-1:0] value);
      limit_of[idx] = value;
   endfunction

   function int first_free(int lo, int cnt);
      for (int i = lo; i < lo + cnt; i++)
         if (!slot_busy[i]) return i;
      return -1;
   endfunction

   function int free_count();
      int n;
      n = 0;
      for (int i = 0; i < POOL_SLOTS; i++)
         if (!slot_busy[i]) n++;
      return n;
   endfunction

   // stamps handed out but not yet read back
   function int backlog();
      bit [15:0] o;
      o = next_stamp - next_read;
      return int'(o);
   endfunction

   function bit unread(int i);
      bit [15:0] d;
      bit [15:0] o;
      d = slot_stamp[i] - next_read;
      o = next_stamp - next_read;
      return slot_busy[i] && (d < o);
   endfunction

   // a used slot whose word was already read, else an index beyond the pool
   function logic [SLOT_W-1:0] pick_release();
      int spent [$];
      for (int i = 0; i < POOL_SLOTS; i++)
         if (slot_busy[i] && !unread(i)) spent.push_back(i);
      if (spent.size() == 0) return SLOT_W'(POOL_SLOTS + $urandom_range(0, 3));
      return SLOT_W'(spent[$urandom_range(0, spent.size() - 1)]);
   endfunction

   // work out the result of one accepted word and update the pool
   function void take_request(logic [OP_W-1:0] op, logic [LEN_W-1:0] len,
                              logic [SLOT_W-1:0] sl);
      pool_result_type r;
      int s;
      r = '0;
      r.status = ST_OK;
      s = -1;
      case (op)
         OP_ALLOC: begin
            if (len < limit_of[REG_SMALL_LIMIT]) s = first_free(0, POOL_SMALL);
            if (s < 0 && len < limit_of[REG_MEDIUM_LIMIT])
               s = first_free(POOL_SMALL, POOL_MEDIUM);
            if (s < 0 && len < limit_of[REG_LARGE_LIMIT])
               s = first_free(POOL_SMALL + POOL_MEDIUM, POOL_LARGE);
            if (s < 0) begin
               r.status = ST_FAIL;
            end else begin
               slot_busy[s] = 1;
               slot_len[s] = len;
               slot_stamp[s] = next_stamp;
               r.slot = SLOT_W'(s);
               r.size = len;
               r.seq = next_stamp;
               next_stamp++;
            end
         end
         OP_READ: begin
            for (int i = 0; i < POOL_SLOTS && s < 0; i++)
               if (slot_busy[i] && slot_stamp[i] == next_read) s = i;
            if (s < 0) begin
               r.status = ST_FAIL;
            end else begin
               r.slot = SLOT_W'(s);
               r.size = slot_len[s];
               r.seq = slot_stamp[s];
               next_read++;
            end
         end
         OP_RELEASE: begin
            r.slot = sl;
            if (sl >= POOL_SLOTS) begin
               r.status = ST_FAIL;
            end else begin
               slot_busy[sl] = 0;
               slot_len[sl] = '0;
               slot_stamp[sl] = '0;
            end
         end
         default: r.status = ST_FAIL;
      endcase
      due_results.push_back(r);
   endfunction

   function void check_response(logic status, logic [SLOT_W-1:0] slot,
                                logic [LEN_W-1:0] size, logic [SEQ_OUT_W-1:0] seq);
      pool_result_type want;
      if (due_results.size() == 0) begin
         $error("result word with none expected: status %0d slot_out %0d", status, slot);
         faults++;
         return;
      end
      want = due_results.pop_front();
      if (status !== want.status) begin
         $error("status: expected %0d, got %0d", want.status, status);
         faults++;
      end
      if (slot !== want.slot) begin
         $error("slot_out: expected %0d, got %0d", want.slot, slot);
         faults++;
      end
      if (size !== want.size) begin
         $error("size_out: expected %0d, got %0d", want.size, size);
         faults++;
      end
      if (seq !== want.seq) begin
         $error("seq_out: expected %0d, got %0d", want.seq, seq);
         faults++;
      end
   endfunction
endclass

module tb_size_class_buffer_pool_in_order;

   localparam logic [OP_W-1:0] OP_NONE = 2'd3;
   localparam bit CSR_WR = 1'b1;
   localparam bit CSR_RD = 1'b0;
   localparam int LEN_MAX = 2097151;
   localparam int LIMIT_MAX = 2097152;
   localparam int CYCLE_LIMIT = 4_000_000;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASES = 8;
   localparam int PHASE_WORDS = 115;
   localparam int TAIL_ROUNDS = 20;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [CSR_AW-1:0] paddr = '0;
   logic [CSR_DW-1:0] pwdata = '0;
   logic [CSR_DW-1:0] prdata;
   logic              pready;

   scbp_req_if req_ch ();
   scbp_rsp_if rsp_ch ();

   slot_pool_model pool = new();
   int gap_pct = 0;
   bit hold_rsp = 0;
   int csr_faults = 0;
   int cycle_count = 0;

   size_class_buffer_pool_in_order dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // result side: random stalls, plus one long hold-off on request
   initial begin
      int burst;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_ch.ready = 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_rsp = 0;
         end else if (gap_pct > 0 && $urandom_range(0, 399) < gap_pct) begin
            burst = $urandom_range(1, 18);
            rsp_ch.ready = 1'b0;
            repeat (burst - 1) @(negedge clock);
         end else begin
            rsp_ch.ready = 1'b1;
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         pool.check_response(rsp_ch.status, rsp_ch.slot_out, rsp_ch.size_out, rsp_ch.seq_out);
   end

   task automatic send_word(logic [OP_W-1:0] op, logic [LEN_W-1:0] len,
                            logic [SLOT_W-1:0] sl);
      @(negedge clock);
      req_ch.valid = 1'b1;
      req_ch.opcode = op;
      req_ch.length = len;
      req_ch.slot_in = sl;
      do @(posedge clock); while (!req_ch.ready);
      pool.take_request(op, len, sl);
   endtask

   task automatic idle_req(int n);
      repeat (n) begin
         @(negedge clock);
         req_ch.valid = 1'b0;
      end
   endtask

   // wait until every result word is in and the block has settled
   task automatic drain();
      idle_req(1);
      while (pool.due_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic apb_access(bit wr, logic [1:0] idx, logic [CSR_DW-1:0] data);
      @(negedge clock);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = wr;
      paddr = {idx, 2'b00};
      pwdata = data;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      if (wr) begin
         pool.set_limit(idx, data[LIMIT_W-1:0]);
      end else if (prdata !== CSR_DW'(pool.limit_of[idx])) begin
         $error("limit register %0d: expected %0d, got %0d", idx, pool.limit_of[idx], prdata);
         csr_faults++;
      end
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   // write all three limits, then read them back
   task automatic program_limits(logic [LIMIT_W-1:0] s, logic [LIMIT_W-1:0] m,
                                 logic [LIMIT_W-1:0] l);
      logic [1:0] regs [3];
      logic [LIMIT_W-1:0] vals [3];
      regs = '{REG_SMALL_LIMIT, REG_MEDIUM_LIMIT, REG_LARGE_LIMIT};
      vals = '{s, m, l};
      for (int i = 0; i < 3; i++) apb_access(CSR_WR, regs[i], CSR_DW'(vals[i]));
      for (int i = 0; i < 3; i++) apb_access(CSR_RD, regs[i], '0);
   endtask

   function automatic logic [LIMIT_W-1:0] pick_limit();
      case ($urandom_range(0, 4))
         0: return '0;
         1: return LIMIT_W'(LIMIT_MAX);
         2: return LIMIT_W'($urandom_range(0, LIMIT_MAX));
         default: return LIMIT_W'($urandom_range(0, 1 << 19));
      endcase
   endfunction

   // lengths cluster around the class limits so every class boundary is hit
   function automatic logic [LEN_W-1:0] pick_length();
      int v;
      int lim;
      lim = int'(pool.limit_of[$urandom_range(0, 2)]);
      case ($urandom_range(0, 9))
         0: v = 0;
         1: v = LEN_MAX;
         2, 3: v = lim + int'($urandom_range(0, 2)) - 1;
         4, 5, 6: v = int'($urandom_range(0, lim));
         default: v = int'($urandom_range(0, LEN_MAX));
      endcase
      if (v < 0) v = 0;
      if (v > LEN_MAX) v = LEN_MAX;
      return LEN_W'(v);
   endfunction

   // mostly allocate / read / release in order, some noise
   task automatic random_word();
      logic [OP_W-1:0] op;
      logic [LEN_W-1:0] len;
      logic [SLOT_W-1:0] sl;
      int r;
      len = pick_length();
      sl = pool.pick_release();
      r = $urandom_range(0, 99);
      if (r < 15) begin
         // any opcode and slot, but never free a slot whose word is still unread
         op = OP_W'($urandom_range(0, 3));
         sl = SLOT_W'($urandom_range(0, 15));
         if (sl < POOL_SLOTS && pool.unread(sl)) sl = pool.pick_release();
      end else if (pool.free_count() == 0) begin
         op = (pool.backlog() > 0) ? OP_READ : OP_RELEASE;
      end else if (r < 55) begin
         op = OP_ALLOC;
      end else if (r < 80) begin
         op = OP_READ;
      end else begin
         op = OP_RELEASE;
      end
      send_word(op, len, sl);
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.opcode = OP_ALLOC;
      req_ch.length = '0;
      req_ch.slot_in = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: read on empty pool, class boundaries at reset limits
      send_word(OP_READ, '0, '0);
      send_word(OP_ALLOC, '0, '0);
      send_word(OP_ALLOC, LEN_W'(131071), '0);
      send_word(OP_ALLOC, LEN_W'(131072), '0);
      send_word(OP_ALLOC, LEN_W'(524288), '0);
      send_word(OP_ALLOC, LEN_W'(1048576), '0);
      send_word(OP_ALLOC, LEN_W'(LEN_MAX), '0);
      send_word(OP_READ, '0, '0);
      // release, double release, out of range indexes, unused opcode
      send_word(OP_RELEASE, '0, 4'd0);
      send_word(OP_RELEASE, '0, 4'd0);
      send_word(OP_RELEASE, '0, 4'd12);
      send_word(OP_RELEASE, LEN_W'(LEN_MAX), 4'd15);
      send_word(OP_NONE, LEN_W'(LEN_MAX), 4'd15);
      // fill the small class so the last one falls through to medium
      repeat (5) send_word(OP_ALLOC, LEN_W'(100), '0);
      repeat (3) send_word(OP_READ, '0, '0);
      drain();

      // random phases, each under its own limits
      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph == 0)
            program_limits('0, '0, '0);
         else if (ph == 1)
            program_limits(LIMIT_W'(LIMIT_MAX), LIMIT_W'(LIMIT_MAX), LIMIT_W'(LIMIT_MAX));
         else if (ph == PHASES - 1)
            program_limits(SMALL_LIMIT_RST, MEDIUM_LIMIT_RST, LARGE_LIMIT_RST);
         else
            program_limits(pick_limit(), pick_limit(), pick_limit());
         if (ph == 2) hold_rsp = 1;
         for (int n = 0; n < PHASE_WORDS; n++) begin
            if (n % 25 == 0) begin
               case ($urandom_range(0, 3))
                  0: gap_pct = 0;
                  1: gap_pct = 10;
                  2: gap_pct = 30;
                  default: gap_pct = 60;
               endcase
            end
            if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct)
               idle_req($urandom_range(1, 18));
            random_word();
         end
         drain();
      end

      // no idling from here: empty the pool, then back-to-back alloc, read, release
      gap_pct = 0;
      while (pool.backlog() > 0) send_word(OP_READ, '0, '0);
      for (int i = 0; i < POOL_SLOTS; i++)
         if (pool.slot_busy[i]) send_word(OP_RELEASE, '0, SLOT_W'(i));
      repeat (TAIL_ROUNDS) begin
         send_word(OP_ALLOC, LEN_W'($urandom_range(0, 1048575)), '0);
         send_word(OP_READ, '0, '0);
         send_word(OP_RELEASE, '0, pool.pick_release());
      end

      // freeing a slot before its word is read leaves the read with nothing
      send_word(OP_ALLOC, '0, '0);
      send_word(OP_RELEASE, '0, pool.due_results[$].slot);
      send_word(OP_READ, '0, '0);
      drain();
      repeat (16) @(posedge clock);

      if (pool.faults == 0 && csr_faults == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

FILE: sim.f
sv/scbp_pkg.sv
sv/scbp_req_if.sv
sv/scbp_rsp_if.sv
sv/scbp_csr.sv
sv/scbp_ctrl.sv
sv/scbp_datapath.sv
sv/size_class_buffer_pool_in_order.sv
sv/scbp_checker.sv
sim/tb_size_class_buffer_pool_in_order.sv
